// ===== rtl/core/segment_circle_collision_test_macros.svh =====
// Assertion macros shared by the collision test RTL.
`ifndef SEGMENT_CIRCLE_COLLISION_TEST_MACROS_SVH
`define SEGMENT_CIRCLE_COLLISION_TEST_MACROS_SVH

// same-cycle implication, disabled during reset
`define SCCT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define SCCT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/scct_pkg.sv =====
// Shared constants and register index codes for the collision test block.
package scct_pkg;

  localparam int RADIUS_BITS    = 12;
  localparam int CFG_INDEX_BITS = 3;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_SEG_A_X       = 3'd0,
    REG_SEG_A_Y       = 3'd1,
    REG_SEG_B_X       = 3'd2,
    REG_SEG_B_Y       = 3'd3,
    REG_BALL_RADIUS   = 3'd4
  } cfg_reg_t;

endpackage

// ===== rtl/core/segment_circle_collision_test.sv =====
// Moving disc against fixed wall segment: pipelined collision test.
//
//  channel   signals                             direction  handshake
//  query     ball_x ball_y vel_x vel_y           in         query_valid / query_stall
//  result    collides                            out        result_valid / result_stall
//  cfg       cfg_index cfg_data                  in         cfg_valid / cfg_ready
//
// Seven register stages: differences, products, sums, compares and abs,
// split products of the squared distance test, their sums, final decision.
// One item per cycle while the result is not stalled; result_valid rises once an accepted item reaches the last stage.
// Each stage loads when it is empty or the stage after it moves, so bubbles
// fill while the result is stalled; query_stall rises only with a full pipe.
// Synchronous reset clears the valid bits and the configuration registers.
module segment_circle_collision_test #(
  parameter int COORD_BITS = 16,
  localparam int CFG_BITS = (COORD_BITS > scct_pkg::RADIUS_BITS) ?
                            COORD_BITS : scct_pkg::RADIUS_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 query_valid,
  output logic                                 query_stall,
  input  logic signed [COORD_BITS-1:0]         ball_x,
  input  logic signed [COORD_BITS-1:0]         ball_y,
  input  logic signed [COORD_BITS-1:0]         vel_x,
  input  logic signed [COORD_BITS-1:0]         vel_y,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output logic                                 collides,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [scct_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [CFG_BITS-1:0]                  cfg_data
);

  import scct_pkg::*;

`include "segment_circle_collision_test_macros.svh"

  localparam int N   = 7;
  localparam int DW  = COORD_BITS + 1;
  localparam int PW  = 2 * DW;
  localparam int SW  = PW + 1;
  localparam int R2W = 2 * RADIUS_BITS;
  localparam int EW  = (SW > R2W) ? SW : R2W;
  localparam int H   = (SW + 1) / 2;
  localparam int HW  = SW - H;
  localparam int CW  = (2 * SW > SW + R2W) ? 2 * SW : SW + R2W;

  // configuration
  logic signed [COORD_BITS-1:0] seg_ax, seg_ay, seg_bx, seg_by;
  logic [RADIUS_BITS-1:0]       radius;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_ax <= '0;
      seg_ay <= '0;
      seg_bx <= '0;
      seg_by <= '0;
      radius <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SEG_A_X:     seg_ax <= cfg_data[COORD_BITS-1:0];
        REG_SEG_A_Y:     seg_ay <= cfg_data[COORD_BITS-1:0];
        REG_SEG_B_X:     seg_bx <= cfg_data[COORD_BITS-1:0];
        REG_SEG_B_Y:     seg_by <= cfg_data[COORD_BITS-1:0];
        REG_BALL_RADIUS: radius <= cfg_data[RADIUS_BITS-1:0];
        default: ;
      endcase
    end
  end

  // stage flow control
  logic [N:1] v;
  logic [N:1] v_in;
  logic [N:1] adv;

  always_comb begin
    adv[N] = !v[N] || !result_stall;
    for (int k = N - 1; k >= 1; k--) begin
      adv[k] = !v[k] || adv[k+1];
    end
  end

  assign v_in = {v[N-1:1], query_valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 1; k <= N; k++) begin
        if (adv[k]) v[k] <= v_in[k];
      end
    end
  end

  assign query_stall  = !adv[1];
  assign result_valid = v[N];

  // stage 1: differences
  logic signed [DW-1:0] s1_asx, s1_asy, s1_bsx, s1_bsy;
  logic signed [DW-1:0] s1_vx, s1_vy, s1_abx, s1_aby;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s1_asx <= DW'(ball_x) - DW'(seg_ax);
      s1_asy <= DW'(ball_y) - DW'(seg_ay);
      s1_bsx <= DW'(ball_x) - DW'(seg_bx);
      s1_bsy <= DW'(ball_y) - DW'(seg_by);
      s1_vx  <= DW'(vel_x);
      s1_vy  <= DW'(vel_y);
      s1_abx <= DW'(seg_bx) - DW'(seg_ax);
      s1_aby <= DW'(seg_by) - DW'(seg_ay);
    end
  end

  // stage 2: products
  logic signed [PW-1:0] s2_c1, s2_c2, s2_a1, s2_a2, s2_b1, s2_b2;
  logic signed [PW-1:0] s2_l1, s2_l2, s2_d1, s2_d2, s2_x1, s2_x2;
  logic [R2W-1:0]       s2_r2;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s2_c1 <= s1_abx * s1_vy;
      s2_c2 <= s1_aby * s1_vx;
      s2_a1 <= s1_asx * s1_asx;
      s2_a2 <= s1_asy * s1_asy;
      s2_b1 <= s1_bsx * s1_bsx;
      s2_b2 <= s1_bsy * s1_bsy;
      s2_l1 <= s1_abx * s1_abx;
      s2_l2 <= s1_aby * s1_aby;
      s2_d1 <= s1_abx * s1_asx;
      s2_d2 <= s1_aby * s1_asy;
      s2_x1 <= s1_abx * s1_asy;
      s2_x2 <= s1_aby * s1_asx;
      s2_r2 <= radius * radius;
    end
  end

  // stage 3: sums
  logic signed [SW-1:0] s3_cv, s3_dot, s3_cr, s3_len2;
  logic [SW-1:0]        s3_sa, s3_sb;
  logic [R2W-1:0]       s3_r2;

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s3_cv   <= SW'(s2_c1) - SW'(s2_c2);
      s3_sa   <= unsigned'(SW'(s2_a1) + SW'(s2_a2));
      s3_sb   <= unsigned'(SW'(s2_b1) + SW'(s2_b2));
      s3_len2 <= SW'(s2_l1) + SW'(s2_l2);
      s3_dot  <= SW'(s2_d1) + SW'(s2_d2);
      s3_cr   <= SW'(s2_x1) - SW'(s2_x2);
      s3_r2   <= s2_r2;
    end
  end

  // stage 4: approach, endpoint and foot tests, |cross|
  logic           s4_app, s4_end, s4_on;
  logic [SW-1:0]  s4_mag, s4_len2;
  logic [R2W-1:0] s4_r2;

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      s4_app  <= !s3_cv[SW-1] && (s3_cv != '0);
      s4_end  <= (EW'(s3_sa) <= EW'(s3_r2)) || (EW'(s3_sb) <= EW'(s3_r2));
      s4_on   <= !s3_dot[SW-1] && (s3_dot <= s3_len2);
      s4_mag  <= s3_cr[SW-1] ? unsigned'(-s3_cr) : unsigned'(s3_cr);
      s4_len2 <= unsigned'(s3_len2);
      s4_r2   <= s3_r2;
    end
  end

  // stage 5: split products for cross^2 and len2 * r^2
  logic               s5_app, s5_end, s5_on;
  logic [2*HW-1:0]    s5_hh;
  logic [SW-1:0]      s5_hl;
  logic [2*H-1:0]     s5_ll;
  logic [HW+R2W-1:0]  s5_lh;
  logic [H+R2W-1:0]   s5_lo;

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      s5_app <= s4_app;
      s5_end <= s4_end;
      s5_on  <= s4_on;
      s5_hh  <= s4_mag[SW-1:H] * s4_mag[SW-1:H];
      s5_hl  <= s4_mag[SW-1:H] * s4_mag[H-1:0];
      s5_ll  <= s4_mag[H-1:0] * s4_mag[H-1:0];
      s5_lh  <= s4_len2[SW-1:H] * s4_r2;
      s5_lo  <= s4_len2[H-1:0] * s4_r2;
    end
  end

  // stage 6: recombine
  logic          s6_app, s6_end, s6_on;
  logic [CW-1:0] s6_sq, s6_lr;

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      s6_app <= s5_app;
      s6_end <= s5_end;
      s6_on  <= s5_on;
      s6_sq  <= (CW'(s5_hh) << (2 * H)) + (CW'(s5_hl) << (H + 1)) + CW'(s5_ll);
      s6_lr  <= (CW'(s5_lh) << H) + CW'(s5_lo);
    end
  end

  // stage 7: decision
  always_ff @(posedge clk) begin
    if (adv[7]) begin
      collides <= s6_app && (s6_end || (s6_on && (s6_sq <= s6_lr)));
    end
  end

  `SCCT_ASSERT_NOW(a_stall_only_when_full, clk, rst, query_stall,
                   (result_valid && result_stall && (v == '1)),
                   "input stalled without a full, stalled pipe")
  `SCCT_ASSERT_NOW(a_degenerate_no_hit, clk, rst,
                   (result_valid && (seg_ax == seg_bx) && (seg_ay == seg_by)), !collides,
                   "degenerate segment reported a collision")
  `SCCT_ASSERT_NEXT(a_accept_enters_stage1, clk, rst, (query_valid && !query_stall), v[1],
                    "accepted item missing from first stage")

endmodule
